/* hdl/assert_macros.svh */
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, masked while reset is applied
`define SPPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// same-cycle implication
`define SPPR_ASSERT_IMP(lbl, ante, cons, msg) \
  `SPPR_ASSERT(lbl, (ante) |-> (cons), msg)

// next-cycle implication
`define SPPR_ASSERT_NXT(lbl, ante, cons, msg) \
  `SPPR_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

/* hdl/sppr_pkg.sv */
package sppr_pkg;

  localparam int CORDIC_ITER = 20;
  localparam int IW          = $clog2(CORDIC_ITER);
  localparam int GUARD       = 6;
  // coordinate width: Q.14 metres with cordic growth headroom
  localparam int CW          = 35;
  // angle width: 32 bit binary angle plus a sign bit
  localparam int AW          = 33;
  localparam int KW          = 25;
  localparam logic signed [KW-1:0] CORDIC_KQ = 25'sd10188014;
  // ungain multiply split
  localparam int UG_LO       = 17;
  localparam int UG_HI       = CW - UG_LO;
  localparam int PW          = UG_HI + KW;
  localparam int SW          = PW + UG_LO + 1;
  localparam int UG_SHIFT    = 24;
  localparam int UG_LAT      = 2;

  localparam logic [31:0] ATAN_TAB [CORDIC_ITER] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518
  };

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [AW-1:0] ang_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    ang_t   z;
  } lane_t;

  typedef enum logic [2:0] {
    CFG_OLD_X   = 3'd0,
    CFG_OLD_Y   = 3'd1,
    CFG_OLD_HDG = 3'd2,
    CFG_NOW_X   = 3'd3,
    CFG_NOW_Y   = 3'd4,
    CFG_NOW_HDG = 3'd5,
    CFG_LIMIT   = 3'd6
  } cfg_idx_e;

  localparam logic [15:0] LIMIT_RST = 16'd7680;

  function automatic logic [31:0] atan_at(input logic [IW-1:0] i);
    atan_at = ATAN_TAB[i];
  endfunction

  // fold angles in the left half plane by half a turn before rotation
  function automatic lane_t rot_prep(input coord_t x, input coord_t y,
                                     input logic [15:0] a);
    lane_t       l;
    logic        flip;
    logic [15:0] a2;
    flip = a[15] ^ a[14];
    a2   = flip ? (a ^ 16'h8000) : a;
    l.x  = flip ? -x : x;
    l.y  = flip ? -y : y;
    l.z  = $signed({a2[15], a2, 16'h0000});
    return l;
  endfunction

endpackage

/* hdl/scan_point_pose_reprojection_top.sv */
// Reprojects one lidar point (range, bearing) from an older scan frame into
// the current robot frame. The point is rotated by bearing plus old heading
// minus current heading, the pose offset is rotated by minus current heading
// and added, and the sum goes back to range and bearing through a cordic
// vectoring pass. Range is clamped to range_limit; a point whose range equals
// range_limit keeps it and flags kept_as_limit. Throughput is one point per
// clock while result beats are taken. From input beat to result beat a point
// passes 20 rotation cells, 2 ungain stages, 1 add stage, 20 vectoring cells,
// 2 ungain stages and the output register. The whole chain advances together,
// so a held result beat stalls the chain and input ready drops with it. The
// config port is always ready; write it only while no point is in flight.
module scan_point_pose_reprojection_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  // point input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] range_in_i,
  input  logic signed [15:0] bearing_in_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] range_out_o,
  output logic signed [15:0] bearing_out_o,
  output logic        kept_as_limit_o
);
  import sppr_pkg::*;

  localparam int L1 = CORDIC_ITER + UG_LAT;

  // config registers
  logic [23:0] old_x_q, old_y_q, now_x_q, now_y_q;
  logic [15:0] old_h_q, now_h_q, limit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      old_x_q <= '0;
      old_y_q <= '0;
      old_h_q <= '0;
      now_x_q <= '0;
      now_y_q <= '0;
      now_h_q <= '0;
      limit_q <= LIMIT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_OLD_X:   old_x_q <= cfg_data_i;
        CFG_OLD_Y:   old_y_q <= cfg_data_i;
        CFG_OLD_HDG: old_h_q <= cfg_data_i[15:0];
        CFG_NOW_X:   now_x_q <= cfg_data_i;
        CFG_NOW_Y:   now_y_q <= cfg_data_i;
        CFG_NOW_HDG: now_h_q <= cfg_data_i[15:0];
        CFG_LIMIT:   limit_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // whole chain moves when the output register can take a beat
  logic en, acc;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;
  assign acc        = in_valid_i && en;

  // entry: point and pose offset prepared for rotation
  logic [15:0] ang_p, ang_off;
  coord_t      px0, dx0, dy0;
  lane_t       rp [CORDIC_ITER+1];
  lane_t       rt [CORDIC_ITER+1];

  assign ang_p   = 16'(bearing_in_i) + old_h_q - now_h_q;
  assign ang_off = 16'd0 - now_h_q;
  assign px0   = $signed({{(CW-16-GUARD){1'b0}}, range_in_i, {GUARD{1'b0}}});
  assign dx0   = ($signed({{(CW-24){old_x_q[23]}}, old_x_q})
                - $signed({{(CW-24){now_x_q[23]}}, now_x_q})) <<< GUARD;
  assign dy0   = ($signed({{(CW-24){old_y_q[23]}}, old_y_q})
                - $signed({{(CW-24){now_y_q[23]}}, now_y_q})) <<< GUARD;
  assign rp[0] = rot_prep(px0, '0, ang_p);
  assign rt[0] = rot_prep(dx0, dy0, ang_off);

  // rotation chain, point and offset lanes side by side
  for (genvar g = 0; g < CORDIC_ITER; g++) begin : g_rot
    sppr_rot_cell u_rp (
      .clk_i, .en_i(en), .iter_i(IW'(g)), .lane_i(rp[g]), .lane_o(rp[g+1])
    );
    sppr_rot_cell u_rt (
      .clk_i, .en_i(en), .iter_i(IW'(g)), .lane_i(rt[g]), .lane_o(rt[g+1])
    );
  end

  coord_t ux_p, uy_p, ux_t, uy_t;
  sppr_ungain u_ug_px (.clk_i, .en_i(en), .v_i(rp[CORDIC_ITER].x), .v_o(ux_p));
  sppr_ungain u_ug_py (.clk_i, .en_i(en), .v_i(rp[CORDIC_ITER].y), .v_o(uy_p));
  sppr_ungain u_ug_tx (.clk_i, .en_i(en), .v_i(rt[CORDIC_ITER].x), .v_o(ux_t));
  sppr_ungain u_ug_ty (.clk_i, .en_i(en), .v_i(rt[CORDIC_ITER].y), .v_o(uy_t));

  // beat tracking through the rotation half
  logic m1_vld_q  [L1];
  logic m1_kept_q [L1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < L1; i++) m1_vld_q[i] <= 1'b0;
    end else if (en) begin
      m1_vld_q[0] <= acc;
      for (int i = 1; i < L1; i++) m1_vld_q[i] <= m1_vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_kept_q[0] <= (range_in_i == limit_q);
      for (int i = 1; i < L1; i++) m1_kept_q[i] <= m1_kept_q[i-1];
    end
  end

  // add stage
  logic   s_vld_q, s_kept_q;
  coord_t sx_q, sy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s_vld_q <= 1'b0;
    else if (en) s_vld_q <= m1_vld_q[L1-1];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s_kept_q <= m1_kept_q[L1-1];
      sx_q     <= ux_p + ux_t;
      sy_q     <= uy_p + uy_t;
    end
  end

  // vectoring entry: left half plane folded by half a turn
  logic  s_zero, s_neg;
  lane_t vl [CORDIC_ITER+1];

  assign s_zero  = (sx_q == '0) && (sy_q == '0);
  assign s_neg   = sx_q[CW-1];
  assign vl[0].x = s_neg ? -sx_q : sx_q;
  assign vl[0].y = s_neg ? -sy_q : sy_q;
  assign vl[0].z = s_neg ? $signed({1'b0, 32'h8000_0000}) : '0;

  for (genvar g = 0; g < CORDIC_ITER; g++) begin : g_vec
    sppr_vec_cell u_vc (
      .clk_i, .en_i(en), .iter_i(IW'(g)), .lane_i(vl[g]), .lane_o(vl[g+1])
    );
  end

  coord_t mag;
  sppr_ungain u_ug_mag (.clk_i, .en_i(en), .v_i(vl[CORDIC_ITER].x), .v_o(mag));

  // beat tracking through the vectoring half
  logic        m2_vld_q  [L1];
  logic        m2_kept_q [L1];
  logic        m2_zero_q [L1];
  logic [31:0] ang_q     [UG_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < L1; i++) m2_vld_q[i] <= 1'b0;
    end else if (en) begin
      m2_vld_q[0] <= s_vld_q;
      for (int i = 1; i < L1; i++) m2_vld_q[i] <= m2_vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m2_kept_q[0] <= s_kept_q;
      m2_zero_q[0] <= s_zero;
      for (int i = 1; i < L1; i++) begin
        m2_kept_q[i] <= m2_kept_q[i-1];
        m2_zero_q[i] <= m2_zero_q[i-1];
      end
      ang_q[0] <= vl[CORDIC_ITER].z[31:0];
      for (int i = 1; i < UG_LAT; i++) ang_q[i] <= ang_q[i-1];
    end
  end

  // output: round to q8.8, clamp, marker override, bearing rounding
  coord_t      r, lim_w;
  logic [15:0] rout_d, bout_d;
  logic [31:0] bsum;
  logic        zero_f, kept_f;

  assign zero_f = m2_zero_q[L1-1];
  assign kept_f = m2_kept_q[L1-1];
  assign r      = (mag + (CW'(1) <<< (GUARD - 1))) >>> GUARD;
  assign lim_w  = $signed({{(CW-16){1'b0}}, limit_q});
  assign bsum   = ang_q[UG_LAT-1] + 32'h0000_8000;

  always_comb begin
    if (kept_f)              rout_d = limit_q;
    else if (zero_f || r[CW-1]) rout_d = '0;
    else if (r > lim_w)      rout_d = limit_q;
    else                     rout_d = r[15:0];
    bout_d = zero_f ? 16'd0 : bsum[31:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (en) out_valid_o <= m2_vld_q[L1-1];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      range_out_o     <= rout_d;
      bearing_out_o   <= bout_d;
      kept_as_limit_o <= kept_f;
    end
  end

endmodule

/* hdl/sppr_rot_cell.sv */
module sppr_rot_cell (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [sppr_pkg::IW-1:0] iter_i,
  input  sppr_pkg::lane_t       lane_i,
  output sppr_pkg::lane_t       lane_o
);
  import sppr_pkg::*;

  lane_t  lane_d, lane_q;
  coord_t xs, ys;
  ang_t   at;

  always_comb begin
    xs = lane_i.x >>> iter_i;
    ys = lane_i.y >>> iter_i;
    at = $signed({1'b0, atan_at(iter_i)});
    if (!lane_i.z[AW-1]) begin
      lane_d.x = lane_i.x - ys;
      lane_d.y = lane_i.y + xs;
      lane_d.z = lane_i.z - at;
    end else begin
      lane_d.x = lane_i.x + ys;
      lane_d.y = lane_i.y - xs;
      lane_d.z = lane_i.z + at;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) lane_q <= lane_d;
  end

  assign lane_o = lane_q;

endmodule

/* hdl/sppr_vec_cell.sv */
module sppr_vec_cell (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [sppr_pkg::IW-1:0] iter_i,
  input  sppr_pkg::lane_t       lane_i,
  output sppr_pkg::lane_t       lane_o
);
  import sppr_pkg::*;

  lane_t  lane_d, lane_q;
  coord_t xs, ys;
  ang_t   at;

  // drive y toward zero, angle accumulates modulo a full turn
  always_comb begin
    xs = lane_i.x >>> iter_i;
    ys = lane_i.y >>> iter_i;
    at = $signed({1'b0, atan_at(iter_i)});
    if (!lane_i.y[CW-1]) begin
      lane_d.x = lane_i.x + ys;
      lane_d.y = lane_i.y - xs;
      lane_d.z = lane_i.z + at;
    end else begin
      lane_d.x = lane_i.x - ys;
      lane_d.y = lane_i.y + xs;
      lane_d.z = lane_i.z - at;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) lane_q <= lane_d;
  end

  assign lane_o = lane_q;

endmodule

/* hdl/sppr_ungain.sv */
module sppr_ungain (
  input  logic             clk_i,
  input  logic             en_i,
  input  sppr_pkg::coord_t v_i,
  output sppr_pkg::coord_t v_o
);
  import sppr_pkg::*;

  logic signed [UG_HI-1:0] hi;
  logic signed [UG_HI-1:0] lo;
  logic signed [PW-1:0]    ph_d, ph_q, pl_d, pl_q;
  logic signed [SW-1:0]    sum;
  coord_t                  v_q;

  // split product, high part signed, low part unsigned
  assign hi   = v_i[CW-1:UG_LO];
  assign lo   = $signed({1'b0, v_i[UG_LO-1:0]});
  assign ph_d = hi * CORDIC_KQ;
  assign pl_d = lo * CORDIC_KQ;

  // round half up, floor shift
  assign sum = (SW'(ph_q) <<< UG_LO) + SW'(pl_q) + (SW'(1) <<< (UG_SHIFT - 1));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ph_q <= ph_d;
      pl_q <= pl_d;
      v_q  <= sum[UG_SHIFT +: CW];
    end
  end

  assign v_o = v_q;

endmodule

/* hdl/sppr_checker.sv */
`include "assert_macros.svh"

module sppr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic [2:0]  cfg_index_i,
  input logic [23:0] cfg_data_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] range_out_o,
  input logic [15:0] bearing_out_o,
  input logic        kept_as_limit_o
);
  import sppr_pkg::*;

  // shadow of the range limit as seen on the config port
  logic [15:0] lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= LIMIT_RST;
    end else if (cfg_valid_i && cfg_ready_o && (cfg_index_i == CFG_LIMIT)) begin
      lim_q <= cfg_data_i[15:0];
    end
  end

  `SPPR_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result beat dropped")
  `SPPR_ASSERT_NXT(a_out_stable, out_valid_o && !out_ready_i, $stable(range_out_o) && $stable(bearing_out_o) && $stable(kept_as_limit_o), "stalled beat changed")
  `SPPR_ASSERT_IMP(a_range_clamp, out_valid_o, range_out_o <= lim_q, "range above limit")
  `SPPR_ASSERT_IMP(a_kept_limit, out_valid_o && kept_as_limit_o, range_out_o == lim_q, "marker range not limit")

endmodule

bind scan_point_pose_reprojection_top sppr_checker u_sppr_checker (
  .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
  .out_valid_o, .out_ready_i, .range_out_o,
  .bearing_out_o(bearing_out_o), .kept_as_limit_o
);

/* sim/scan_point_pose_reprojection_top_test.sv */
`timescale 1ns / 100ps

module scan_point_pose_reprojection_top_test;
  import sppr_pkg::*;

  // index past the end of the register list, writes to it must be dropped
  localparam logic [2:0] CFG_UNMAPPED = 3'd7;
  localparam int         CLK_HALF     = 10;
  // pipeline depth plus some slack for the drain at the end
  localparam int         DRAIN_CYCLES = 60;
  localparam int         ITEMS_PER_PHASE = 250;

  typedef struct packed {
    logic [15:0]        rng;
    logic signed [15:0] brg;
    logic               kept;
  } point_res_t;

  typedef struct packed {
    logic [15:0]        rng;
    logic signed [15:0] brg;
    logic               typed;
    point_res_t         res;
  } point_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [23:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [15:0] range_in_i = '0;
  logic signed [15:0] bearing_in_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [15:0] range_out_o;
  logic signed [15:0] bearing_out_o;
  logic kept_as_limit_o;

  // shadow copy of the pose registers
  logic signed [23:0] old_x_q, old_y_q, now_x_q, now_y_q;
  logic signed [15:0] old_hdg_q, now_hdg_q;
  logic [15:0]        limit_q;

  point_res_t pending_points[$];
  int         err_cnt = 0;
  int         beats_seen = 0;
  bit         no_gaps = 1'b0;

  always #CLK_HALF clk_i = ~clk_i;

  scan_point_pose_reprojection_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .range_in_i     (range_in_i),
    .bearing_in_i   (bearing_in_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .range_out_o    (range_out_o),
    .bearing_out_o  (bearing_out_o),
    .kept_as_limit_o(kept_as_limit_o)
  );

  // ---------------------------------------------------------------------------
  // predictor: fixed point cordic, gain removed after each pass
  // ---------------------------------------------------------------------------
  function automatic longint drop_gain(input longint v);
    return (v * longint'(CORDIC_KQ) + (64'sd1 <<< 23)) >>> 24;
  endfunction

  // rotate (x, y) by a 32 bit binary angle
  function automatic void turn_vec(inout longint x, inout longint y,
                                   input bit [31:0] a);
    longint xs, ys, z;
    bit [31:0] q;
    q = a + 32'h4000_0000;
    // left half plane: pre-turn by half a turn
    if (q[31]) begin
      x = -x;
      y = -y;
      a = a + 32'h8000_0000;
    end
    z = longint'(signed'(a));
    for (int i = 0; i < CORDIC_ITER; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(ATAN_TAB[i]);
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(ATAN_TAB[i]);
      end
    end
    x = drop_gain(x);
    y = drop_gain(y);
  endfunction

  // magnitude and angle of (x, y)
  function automatic void polar_of(input longint x, input longint y,
                                   output longint mag, output bit [31:0] ang);
    longint xs, ys;
    ang = '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      ang = 32'h8000_0000;
    end
    for (int i = 0; i < CORDIC_ITER; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        ang = ang + ATAN_TAB[i];
      end else begin
        x = x - ys;
        y = y + xs;
        ang = ang - ATAN_TAB[i];
      end
    end
    mag = drop_gain(x);
  endfunction

  function automatic point_res_t reproject(input logic [15:0] rng,
                                           input logic signed [15:0] brg);
    point_res_t res;
    bit [15:0]  a16, h16;
    bit [31:0]  ang, rnd;
    longint     px, py, tx, ty, sx, sy, mag, r;
    a16 = brg + old_hdg_q - now_hdg_q;
    px  = longint'(rng) * 64;
    py  = 0;
    turn_vec(px, py, {a16, 16'h0000});
    tx  = (longint'(old_x_q) - longint'(now_x_q)) * 64;
    ty  = (longint'(old_y_q) - longint'(now_y_q)) * 64;
    h16 = 16'h0000 - now_hdg_q;
    turn_vec(tx, ty, {h16, 16'h0000});
    sx = px + tx;
    sy = py + ty;
    // point landing exactly on the current origin
    if (sx == 0 && sy == 0) begin
      mag = 0;
      ang = '0;
    end else begin
      polar_of(sx, sy, mag, ang);
    end
    r = (mag + 32) >>> 6;
    if (r < 0) r = 0;
    if (r > longint'(limit_q)) r = longint'(limit_q);
    res.rng  = r[15:0];
    res.kept = 1'b0;
    // no-return marker keeps its range
    if (rng == limit_q) begin
      res.rng  = rng;
      res.kept = 1'b1;
    end
    rnd     = ang + 32'h0000_8000;
    res.brg = rnd[31:16];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // config channel
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_OLD_X:   old_x_q   = data;
      CFG_OLD_Y:   old_y_q   = data;
      CFG_OLD_HDG: old_hdg_q = data[15:0];
      CFG_NOW_X:   now_x_q   = data;
      CFG_NOW_Y:   now_y_q   = data;
      CFG_NOW_HDG: now_hdg_q = data[15:0];
      CFG_LIMIT:   limit_q   = data[15:0];
      default: ;
    endcase
    // idle gap between writes
    @(posedge clk_i);
  endtask

  task automatic load_poses(input logic [23:0] ox, input logic [23:0] oy,
                            input logic [15:0] oh, input logic [23:0] nx,
                            input logic [23:0] ny, input logic [15:0] nh,
                            input logic [15:0] lim);
    // only touch registers with nothing in flight
    wait (pending_points.size() == 0);
    @(posedge clk_i);
    write_reg(CFG_OLD_X, ox);
    write_reg(CFG_OLD_Y, oy);
    write_reg(CFG_OLD_HDG, {8'h00, oh});
    write_reg(CFG_NOW_X, nx);
    write_reg(CFG_NOW_Y, ny);
    write_reg(CFG_NOW_HDG, {8'h00, nh});
    write_reg(CFG_LIMIT, {8'h00, lim});
  endtask

  // ---------------------------------------------------------------------------
  // point input side
  // ---------------------------------------------------------------------------
  task automatic send_point(input logic [15:0] rng, input logic signed [15:0] brg,
                            input bit typed, input point_res_t typed_res);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    range_in_i   <= rng;
    bearing_in_i <= brg;
    in_valid_i   <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    // beat taken at this edge, log what must come out
    pending_points.push_back(typed ? typed_res : reproject(rng, brg));
  endtask

  task automatic random_points(input int n);
    logic [15:0] rng;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 5))
        0:       rng = limit_q;                          // no-return marker
        1:       rng = 16'($urandom_range(0, 255));      // close in
        2:       rng = limit_q + 16'($urandom_range(0, 3)) - 16'd1;
        default: rng = 16'($urandom_range(0, 65535));
      endcase
      send_point(rng, 16'($urandom_range(0, 65535)), 1'b0, '0);
    end
  endtask

  task automatic end_of_burst;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // result side: random back-pressure, one long hold-off mid-run
  // ---------------------------------------------------------------------------
  initial begin
    int hold;
    @(posedge rst_ni);
    forever begin
      if (beats_seen == 400) hold = 300;  // let the chain fill and stall input
      else hold = no_gaps ? 0 : $urandom_range(0, 7);
      if (hold > 0) begin
        out_ready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // result checker, compares every beat with the oldest expected point
  always @(posedge clk_i) begin
    point_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      beats_seen <= beats_seen + 1;
      if (pending_points.size() == 0) begin
        $error("result beat with no point outstanding");
        err_cnt++;
      end else begin
        want = pending_points.pop_front();
        if (range_out_o !== want.rng) begin
          $error("range_out expected %0d got %0d", want.rng, range_out_o);
          err_cnt++;
        end
        if (bearing_out_o !== want.brg) begin
          $error("bearing_out expected %0d got %0d", want.brg, bearing_out_o);
          err_cnt++;
        end
        if (kept_as_limit_o !== want.kept) begin
          $error("kept_as_limit expected %0d got %0d", want.kept, kept_as_limit_o);
          err_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  point_row_t dir_rows[] = '{
    // reset config: zero poses, limit 30 m
    '{16'd7680,  16'sd0,      1'b1, '{16'd7680, 16'sd0, 1'b1}},  // no-return marker
    '{16'd0,     16'sd0,      1'b1, '{16'd0,    16'sd0, 1'b0}},  // lands on origin
    '{16'd0,     16'sd12345,  1'b1, '{16'd0,    16'sd0, 1'b0}},  // origin, any bearing
    '{16'd65535, 16'sd0,      1'b1, '{16'd7680, 16'sd0, 1'b0}},  // clamped to limit
    '{16'd65535, 16'sd32767,  1'b0, '0},
    '{16'd65535, -16'sd32768, 1'b0, '0},
    '{16'd1,     16'sd16384,  1'b0, '0},
    '{16'd1,     -16'sd16384, 1'b0, '0},
    '{16'd7679,  16'sd8192,   1'b0, '0},
    '{16'd7681,  -16'sd8192,  1'b0, '0},
    '{16'd256,   16'sd100,    1'b0, '0},
    '{16'd32768, -16'sd1,     1'b0, '0},
    '{16'd12345, -16'sd20000, 1'b0, '0}
  };

  initial begin
    old_x_q = '0; old_y_q = '0; now_x_q = '0; now_y_q = '0;
    old_hdg_q = '0; now_hdg_q = '0; limit_q = LIMIT_RST;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table against the reset config
    foreach (dir_rows[i])
      send_point(dir_rows[i].rng, dir_rows[i].brg, dir_rows[i].typed, dir_rows[i].res);
    random_points(ITEMS_PER_PHASE - dir_rows.size());
    end_of_burst();

    // moderate poses, no idling on either side
    load_poses(24'd2560, -24'sd1280, 16'd8192, 24'd256, 24'd768, -16'sd4096, 16'd5120);
    // the unmapped index must not disturb anything
    write_reg(CFG_UNMAPPED, 24'hFFFFFF);
    no_gaps = 1'b1;
    random_points(ITEMS_PER_PHASE);
    end_of_burst();
    no_gaps = 1'b0;

    // extremes: far apart poses, headings at the wrap point, widest limit
    load_poses(24'h7FFFFF, 24'h800000, 16'h7FFF, 24'h800000, 24'h7FFFFF, 16'h8000,
               16'hFFFF);
    send_point(16'hFFFF, 16'sh7FFF, 1'b0, '0);
    send_point(16'h0000, -16'sh8000, 1'b0, '0);
    random_points(ITEMS_PER_PHASE);
    end_of_burst();

    // zero limit: every zero range is a marker
    load_poses(-24'sd100, 24'd50, -16'sd32768, 24'd0, 24'd0, 16'sd32767, 16'd0);
    send_point(16'd0, 16'sd0, 1'b0, '0);
    random_points(ITEMS_PER_PHASE);
    end_of_burst();

    // fully random poses
    load_poses(24'($urandom), 24'($urandom), 16'($urandom), 24'($urandom),
               24'($urandom), 16'($urandom), 16'($urandom_range(256, 20000)));
    random_points(ITEMS_PER_PHASE);
    end_of_burst();

    wait (pending_points.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(20ms);
    $display("TEST FAILED");
    $finish;
  end

endmodule
